>>> rtl/core/keyed_xor_pixel_lz_decoder_defines.svh
// Assertion helpers used by the decoder back stage
`ifndef KEYED_XOR_PIXEL_LZ_DECODER_DEFINES_SVH
`define KEYED_XOR_PIXEL_LZ_DECODER_DEFINES_SVH
`define KXP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KXP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

>>> rtl/core/kxpld_pkg.sv
`default_nettype none
package kxpld_pkg;
    typedef struct packed {
        logic       opcode;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [23:0] pixel;
        logic        want_tick;
        logic        finished;
        logic        copy_error;
        logic        wrong_kind;
    } t_out_item;

    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_ENCRYPT = 2'd2;
    localparam logic [1:0] REG_KEY     = 2'd3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    function automatic logic [31:0] crc_entry(input logic [7:0] n);
        logic [31:0] v;
        v = {24'd0, n};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
        end
        return v;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/kxpld_front.sv
`default_nettype none
// Front: takes items, decrypts bytes, keeps the key index.
module kxpld_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_encrypted,
    input  wire [31:0]              i_key_checksum,
    input  wire                     i_push,
    input  wire kxpld_pkg::t_in_item i_item,
    output logic                    o_full,
    output logic                    o_valid,
    output kxpld_pkg::t_in_item     o_item,
    input  wire                     i_advance_key,
    input  wire                     i_take
);
    kxpld_pkg::t_in_item r_item;
    logic                r_valid;
    logic [9:0]          r_key_idx;
    logic [31:0]         w_word;
    logic [7:0]          w_key;

    always_comb begin
        w_word = i_key_checksum ^
                 kxpld_pkg::crc_entry(r_key_idx[9:2] + i_key_checksum[7:0]);
        w_key  = w_word[8*r_key_idx[1:0] +: 8];
    end

    assign o_full  = r_valid && !i_take;
    assign o_valid = r_valid;
    always_comb begin
        o_item = r_item;
        if (i_encrypted && r_item.opcode == kxpld_pkg::OP_BYTE) begin
            o_item.in_byte = r_item.in_byte ^ w_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_key_idx <= '0;
        end else begin
            if (i_take && i_advance_key) r_key_idx <= r_key_idx + 10'd1;
            if (i_push && !o_full) r_valid <= 1'b1;
            else if (i_take) r_valid <= 1'b0;
        end
        if (i_push && !o_full) r_item <= i_item;
    end
endmodule
`default_nettype wire

>>> rtl/core/kxpld_back.sv
`default_nettype none
`include "keyed_xor_pixel_lz_decoder_defines.svh"
// Back: command decode, history ring, result queue.
module kxpld_back #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int HISTORY_PIXELS = 8192
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [10:0]               i_width,
    input  wire [10:0]               i_height,
    input  wire                      i_valid,
    input  wire kxpld_pkg::t_in_item i_item,
    output logic                     o_take,
    output logic                     o_advance_key,
    output kxpld_pkg::t_out_item     o_result,
    output logic                     o_empty,
    input  wire                      i_pop
);
    localparam int HW = $clog2(HISTORY_PIXELS);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HH = $clog2(MAX_HEIGHT + 1);
    localparam int PW = 26;

    localparam logic [3:0] PH_FIRST = 4'd0, PH_CMD = 4'd1, PH_LIT_LO = 4'd2,
        PH_LIT_HI = 4'd3, PH_LIT_DATA = 4'd4, PH_COPY_LO = 4'd5,
        PH_COPY_HI = 4'd6, PH_COPY = 4'd7, PH_DONE = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_bip, n_bip;
    logic [15:0] r_part, n_part;
    logic [7:0]  r_cmd, n_cmd, r_len_lo, n_len_lo;
    logic [16:0] r_run, n_run;
    logic [PW-1:0] r_pos, n_pos, r_src, n_src;
    logic        r_err, n_err;
    logic [23:0] r_hist [HISTORY_PIXELS];

    // Geometry, clamped from the live registers
    logic [WW-1:0] w_w;
    logic [HH-1:0] w_h;
    logic [PW-1:0] w_total;
    always_comb begin
        w_w = (i_width == 11'd0) ? WW'(1) :
              (32'(i_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(i_width);
        w_h = (i_height == 11'd0) ? HH'(1) :
              (32'(i_height) > MAX_HEIGHT) ? HH'(MAX_HEIGHT) : HH'(i_height);
        w_total = PW'(w_w) * PW'(w_h);
    end

    // Result queue: two-entry skid
    kxpld_pkg::t_out_item r_q0, r_q1, w_res;
    logic r_v0, r_v1;
    assign o_empty  = !r_v0;
    assign o_result = r_q0;
    assign o_take   = i_valid && !r_v1;

    // Copy read data with forwarding of the pixel written last cycle
    logic [23:0] r_rd, r_last_pix;
    logic        r_rd_fwd;
    logic [HW-1:0] w_rd_addr;
    logic        w_we;
    logic [23:0] w_wpix, w_cpix;

    logic [PW+1:0] w_src_s, w_off_neg;
    logic [4:0] w_sel;
    logic [16:0] w_n;
    logic [7:0] b;
    logic w_done_now;

    assign w_cpix = r_rd_fwd ? r_last_pix : r_rd;

    always_comb begin
        n_phase = r_phase; n_bip = r_bip; n_part = r_part; n_cmd = r_cmd;
        n_len_lo = r_len_lo; n_run = r_run; n_pos = r_pos; n_src = r_src;
        n_err = r_err;
        w_res = '0; w_we = 1'b0; w_wpix = '0; o_advance_key = 1'b0;
        b = i_item.in_byte;
        w_sel = r_cmd[6:2]; w_n = 17'd0;
        w_off_neg = '0; w_src_s = '0;
        w_done_now = (r_phase != PH_DONE) && (r_pos >= w_total);
        if (o_take) begin
            if (w_done_now) n_phase = PH_DONE;
            if (w_done_now || r_phase == PH_DONE) begin
                n_phase = PH_DONE;
            end else if (i_item.opcode == kxpld_pkg::OP_TICK) begin
                if (r_phase == PH_COPY) begin
                    w_wpix = (r_src < r_pos) ? w_cpix : 24'd0;
                    w_we = 1'b1;
                    w_res.pixel_valid = 1'b1; w_res.pixel = w_wpix;
                    n_pos = r_pos + 1'b1;
                    n_src = r_src + 1'b1;
                    n_run = r_run - 1'b1;
                    if (n_pos >= w_total) n_phase = PH_DONE;
                    else if (n_run == 17'd0) n_phase = PH_CMD;
                end else begin
                    w_res.wrong_kind = 1'b1;
                end
            end else if (r_phase == PH_COPY) begin
                w_res.wrong_kind = 1'b1;
            end else begin
                o_advance_key = 1'b1;
                unique case (r_phase)
                    PH_FIRST, PH_LIT_DATA: begin
                        if (r_bip == 2'd0) begin
                            n_part = {8'd0, b}; n_bip = 2'd1;
                        end else if (r_bip == 2'd1) begin
                            n_part = {b, r_part[7:0]}; n_bip = 2'd2;
                        end else begin
                            w_wpix = {b, r_part}; n_part = '0; n_bip = 2'd0;
                            w_we = 1'b1;
                            w_res.pixel_valid = 1'b1; w_res.pixel = w_wpix;
                            n_pos = r_pos + 1'b1;
                            n_run = (r_phase == PH_LIT_DATA) ? r_run - 1'b1 : r_run;
                            if (n_pos >= w_total) n_phase = PH_DONE;
                            else if (r_phase == PH_FIRST || n_run == 17'd0)
                                n_phase = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        if (b[7]) begin
                            n_cmd = b;
                            w_sel = b[6:2];
                            if (b[1:0] == 2'd3) n_phase = PH_COPY_LO;
                            else w_n = {15'd0, b[1:0]} + 17'd1;
                        end else if (b == 8'h7F) begin
                            n_phase = PH_LIT_LO;
                        end else begin
                            n_run = {9'd0, b} + 17'd1; n_bip = 2'd0;
                            n_phase = PH_LIT_DATA;
                        end
                    end
                    PH_LIT_LO, PH_COPY_LO: begin
                        n_len_lo = b;
                        n_phase = (r_phase == PH_LIT_LO) ? PH_LIT_HI : PH_COPY_HI;
                    end
                    PH_LIT_HI: begin
                        n_run = {1'b0, b, r_len_lo} + 17'h80; n_bip = 2'd0;
                        n_phase = PH_LIT_DATA;
                    end
                    PH_COPY_HI: begin
                        w_n = {1'b0, b, r_len_lo} + 17'd4;
                    end
                    default: n_phase = PH_DONE;
                endcase
                if (w_n != 17'd0) begin
                    if (w_sel < 5'd6)
                        w_off_neg = (PW+2)'(w_sel) + 1'b1;
                    else if (w_sel < 5'd13)
                        w_off_neg = (PW+2)'(w_w) + (PW+2)'(w_sel - 5'd6) - (PW+2)'(3);
                    else if (w_sel < 5'd20)
                        w_off_neg = ((PW+2)'(w_w) << 1) + (PW+2)'(w_sel - 5'd13)
                                  - (PW+2)'(3);
                    else if (w_sel < 5'd27)
                        w_off_neg = ((PW+2)'(w_w) << 1) + (PW+2)'(w_w)
                                  + (PW+2)'(w_sel - 5'd20) - (PW+2)'(3);
                    else
                        w_off_neg = ((PW+2)'(w_w) << 2) + (PW+2)'(w_sel - 5'd27)
                                  - (PW+2)'(2);
                    w_src_s = (PW+2)'(r_pos) - w_off_neg;
                    if (w_src_s[PW+1] ||
                        w_src_s + (PW+2)'(w_n) >= (PW+2)'(w_total)) begin
                        n_err = 1'b1; n_phase = PH_DONE;
                    end else begin
                        n_src = w_src_s[PW-1:0]; n_run = w_n; n_phase = PH_COPY;
                    end
                end
            end
            w_res.want_tick  = (n_phase == PH_COPY);
            w_res.finished   = (n_phase == PH_DONE);
            w_res.copy_error = n_err;
        end
    end

    // Next copy source address for the ring read
    assign w_rd_addr = (o_take) ? n_src[HW-1:0] : r_src[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) r_hist[r_pos[HW-1:0]] <= w_wpix;
        r_rd        <= r_hist[w_rd_addr];
        r_rd_fwd    <= w_we && (r_pos[HW-1:0] == w_rd_addr);
        r_last_pix  <= w_wpix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST; r_bip <= '0; r_part <= '0; r_cmd <= '0;
            r_len_lo <= '0; r_run <= '0; r_pos <= '0; r_src <= '0; r_err <= 1'b0;
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            r_phase <= n_phase; r_bip <= n_bip; r_part <= n_part; r_cmd <= n_cmd;
            r_len_lo <= n_len_lo; r_run <= n_run; r_pos <= n_pos; r_src <= n_src;
            r_err <= n_err;
            // queue: pop from head, push at tail
            if (i_pop && r_v0) begin
                if (r_v1) begin
                    r_q0 <= r_q1; r_v1 <= o_take;
                    if (o_take) r_q1 <= w_res;
                end else begin
                    r_v0 <= o_take;
                    if (o_take) r_q0 <= w_res;
                end
            end else if (o_take) begin
                if (r_v0) begin
                    r_q1 <= w_res; r_v1 <= 1'b1;
                end else begin
                    r_q0 <= w_res; r_v0 <= 1'b1;
                end
            end
        end
    end

    `KXP_ASSERT(a_q_order, i_clk, i_rst_n, !r_v1 || r_v0, "second slot filled while head empty")
    `KXP_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err, r_err && r_phase == PH_DONE, "error not sticky")
    `KXP_ASSERT(a_phase_ok, i_clk, i_rst_n, r_phase <= PH_DONE, "phase code out of range")
endmodule
`default_nettype wire

>>> rtl/core/keyed_xor_pixel_lz_decoder.sv
`default_nettype none
// Keyed XOR pixel LZ decoder.
// Input channel: push/full. Each item is a compressed byte (opcode 0) or a
// tick (opcode 1) that pumps one pixel of a pending copy.
// Result channel: empty/pop. Exactly one result per item, in order, giving
// the pixel (when valid), whether a tick is wanted next, and end/error flags.
// Configuration channel: valid/ready with register index and data; write
// only while idle. A write applies to every item the back stage runs after it.
// An item is held in the front register and executed in the back stage when
// taken; its result is registered into the result queue.
// Throughput: one item per cycle while the result queue has room; the ring
// has one write and one registered read port, the last write forwarded to it.
// Reset puts the decoder back to waiting for the first pixel; the history
// ring is not cleared; a copy source not behind the write position gives 0.
// When the receiver stalls, the two-entry result queue fills and full rises;
// nothing is lost.
module keyed_xor_pixel_lz_decoder #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int HISTORY_PIXELS = 8192
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  wire kxpld_pkg::t_in_item  i_item,
    output logic                      empty,
    input  wire                       pop,
    output kxpld_pkg::t_out_item      o_result,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire [1:0]                 i_cfg_index,
    input  wire [31:0]                i_cfg_data
);
    logic [10:0] r_width, r_height;
    logic        r_encrypted;
    logic [31:0] r_key;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd1; r_height <= 11'd1; r_encrypted <= 1'b0; r_key <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kxpld_pkg::REG_WIDTH:   r_width     <= i_cfg_data[10:0];
                kxpld_pkg::REG_HEIGHT:  r_height    <= i_cfg_data[10:0];
                kxpld_pkg::REG_ENCRYPT: r_encrypted <= i_cfg_data[0];
                kxpld_pkg::REG_KEY:     r_key       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                f_valid, b_take, b_adv;
    kxpld_pkg::t_in_item f_item;

    kxpld_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_encrypted(r_encrypted),
        .i_key_checksum(r_key), .i_push(push), .i_item(i_item), .o_full(full),
        .o_valid(f_valid), .o_item(f_item),
        .i_advance_key(b_adv), .i_take(b_take)
    );

    kxpld_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .HISTORY_PIXELS(HISTORY_PIXELS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_width(r_width), .i_height(r_height),
        .i_valid(f_valid), .i_item(f_item), .o_take(b_take),
        .o_advance_key(b_adv), .o_result(o_result), .o_empty(empty), .i_pop(pop)
    );
endmodule
`default_nettype wire

>>> dv/keyed_xor_pixel_lz_decoder_tb.sv
`timescale 1ns / 1ps

module keyed_xor_pixel_lz_decoder_tb;
    localparam int HIST_DEPTH = 8192;
    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;

    typedef enum logic [3:0] {
        ST_FIRST, ST_CMD, ST_LIT_LO, ST_LIT_HI, ST_LIT_DATA,
        ST_COPY_LO, ST_COPY_HI, ST_COPY, ST_DONE
    } t_dec_state;

    class lz_pixel_scoreboard;
        logic [10:0] width_reg, height_reg;
        bit          enc;
        logic [31:0] key;
        t_dec_state  st;
        int          bip;
        logic [15:0] part;
        logic [7:0]  cmd, len_lo;
        longint      run_left, pos, src;
        logic [9:0]  key_idx;
        bit          err;
        logic [23:0] hist [HIST_DEPTH];
        kxpld_pkg::t_out_item exp_q [$];
        int          errors;

        function new();
            width_reg = 1; height_reg = 1; enc = 0; key = 0;
            st = ST_FIRST; bip = 0; part = 0; cmd = 0; len_lo = 0;
            run_left = 0; pos = 0; src = 0; key_idx = 0; err = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                kxpld_pkg::REG_WIDTH:   width_reg = val[10:0];
                kxpld_pkg::REG_HEIGHT:  height_reg = val[10:0];
                kxpld_pkg::REG_ENCRYPT: enc = val[0];
                kxpld_pkg::REG_KEY:     key = val;
            endcase
        endfunction

        function logic [31:0] crc_table_word(logic [7:0] n);
            logic [31:0] v;
            v = {24'd0, n};
            for (int k = 0; k < 8; k++)
                v = (v >> 1) ^ (v[0] ? 32'hEDB88320 : 32'd0);
            return v;
        endfunction

        function logic [7:0] key_byte(logic [9:0] idx);
            logic [7:0]  w;
            logic [31:0] word;
            w = idx[9:2];
            word = key ^ crc_table_word(w + key[7:0]);
            return 8'(word >> (8 * idx[1:0]));
        endfunction

        function longint width_used();
            if (width_reg < 1) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function longint total();
            longint h;
            h = height_reg;
            if (h < 1) h = 1;
            if (h > MAX_H) h = MAX_H;
            return width_used() * h;
        endfunction

        function longint look(logic [4:0] idx, longint w);
            longint i;
            i = idx;
            if (i < 6) return -1 - i;
            if (i < 13) return 3 - (i - 6) - w;
            if (i < 20) return 3 - (i - 13) - 2 * w;
            if (i < 27) return 3 - (i - 20) - 3 * w;
            return 2 - (i - 27) - 4 * w;
        endfunction

        function void put_pixel(logic [23:0] v);
            hist[pos % HIST_DEPTH] = v;
            pos++;
            if (pos >= total()) st = ST_DONE;
        endfunction

        function bit gather(logic [7:0] b, output logic [23:0] pix);
            pix = 0;
            if (bip == 0) begin
                part = {8'd0, b}; bip = 1; return 0;
            end
            if (bip == 1) begin
                part[15:8] = b; bip = 2; return 0;
            end
            pix = {b, part};
            bip = 0; part = 0;
            return 1;
        endfunction

        function void start_copy(longint n);
            longint s;
            s = pos + look(cmd[6:2], width_used());
            if (s < 0 || s + n >= total()) begin
                err = 1; st = ST_DONE;
                return;
            end
            src = s; run_left = n; st = ST_COPY;
        endfunction

        function void note_item(kxpld_pkg::t_in_item it);
            logic [7:0]  b;
            logic [23:0] pix;
            bit          pv, wk;
            kxpld_pkg::t_out_item r;
            b = it.in_byte; pix = 0; pv = 0; wk = 0;
            if (st != ST_DONE && pos >= total()) st = ST_DONE;
            if (st == ST_DONE) begin
            end else if (it.opcode == kxpld_pkg::OP_TICK) begin
                if (st == ST_COPY) begin
                    pix = (src < pos) ? hist[src % HIST_DEPTH] : 24'd0;
                    pv = 1;
                    put_pixel(pix);
                    src++; run_left--;
                    if (st != ST_DONE && run_left == 0) st = ST_CMD;
                end else begin
                    wk = 1;
                end
            end else if (st == ST_COPY) begin
                wk = 1;
            end else begin
                if (enc) b ^= key_byte(key_idx);
                key_idx++;
                case (st)
                    ST_FIRST: if (gather(b, pix)) begin
                        pv = 1; put_pixel(pix);
                        if (st != ST_DONE) st = ST_CMD;
                    end
                    ST_CMD: begin
                        if (b[7]) begin
                            cmd = b;
                            if (b[1:0] == 2'd3) st = ST_COPY_LO;
                            else start_copy(b[1:0] + 1);
                        end else if (b == 8'h7F) begin
                            st = ST_LIT_LO;
                        end else begin
                            run_left = b + 1; bip = 0; st = ST_LIT_DATA;
                        end
                    end
                    ST_LIT_LO: begin len_lo = b; st = ST_LIT_HI; end
                    ST_LIT_HI: begin
                        run_left = {b, len_lo} + 128; bip = 0; st = ST_LIT_DATA;
                    end
                    ST_LIT_DATA: if (gather(b, pix)) begin
                        pv = 1; put_pixel(pix); run_left--;
                        if (st != ST_DONE && run_left == 0) st = ST_CMD;
                    end
                    ST_COPY_LO: begin len_lo = b; st = ST_COPY_HI; end
                    ST_COPY_HI: start_copy({b, len_lo} + 4);
                    default: st = ST_DONE;
                endcase
            end
            r.pixel_valid = pv;
            r.pixel       = pv ? pix : 24'd0;
            r.want_tick   = (st == ST_COPY);
            r.finished    = (st == ST_DONE);
            r.copy_error  = err;
            r.wrong_kind  = wk;
            exp_q.insert(exp_q.size(), r);
        endfunction

        function void check_result(kxpld_pkg::t_out_item got);
            kxpld_pkg::t_out_item e;
            if (exp_q.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (got.pixel_valid !== e.pixel_valid) begin
                $error("pixel_valid exp %0h got %0h", e.pixel_valid, got.pixel_valid);
                errors++;
            end
            if (got.pixel !== e.pixel) begin
                $error("pixel exp %06h got %06h", e.pixel, got.pixel);
                errors++;
            end
            if (got.want_tick !== e.want_tick) begin
                $error("want_tick exp %0h got %0h", e.want_tick, got.want_tick);
                errors++;
            end
            if (got.finished !== e.finished) begin
                $error("finished exp %0h got %0h", e.finished, got.finished);
                errors++;
            end
            if (got.copy_error !== e.copy_error) begin
                $error("copy_error exp %0h got %0h", e.copy_error, got.copy_error);
                errors++;
            end
            if (got.wrong_kind !== e.wrong_kind) begin
                $error("wrong_kind exp %0h got %0h", e.wrong_kind, got.wrong_kind);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    kxpld_pkg::t_in_item  i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    kxpld_pkg::t_out_item o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = kxpld_pkg::REG_WIDTH;
    logic [31:0] i_cfg_data = '0;

    lz_pixel_scoreboard sb = new();
    int burst_left = 0;
    bit hold_req = 0;

    keyed_xor_pixel_lz_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // Result side: check each transfer, then choose the next pop level
    initial begin
        int mode, stretch, hold_left;
        mode = 0; stretch = 0; hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_result);
            if (hold_req) begin
                hold_left = 300;
                hold_req = 0;
            end
            if (stretch == 0) begin
                mode = $urandom_range(0, 2);
                stretch = $urandom_range(1, 60);
            end
            stretch--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (mode == 0) begin
                pop <= 1'b1;
            end else if (mode == 1) begin
                pop <= ($urandom_range(0, 1) == 1);
            end else begin
                pop <= ($urandom_range(0, 4) == 0);
            end
        end
    end

    task automatic send(bit op, logic [7:0] plain);
        kxpld_pkg::t_in_item it;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        it.opcode = op;
        // encrypt only bytes the decoder will consume
        it.in_byte = (op == kxpld_pkg::OP_BYTE && sb.enc && sb.st != ST_COPY &&
                      sb.st != ST_DONE) ? plain ^ sb.key_byte(sb.key_idx) : plain;
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
        burst_left--;
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] w, logic [31:0] h, logic [31:0] e,
                              logic [31:0] k);
        logic [31:0] vals [4];
        vals = '{w, h, e, k};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(i[1:0], vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Pick a mostly well-formed next item from the predicted decoder state
    task automatic send_random();
        logic [7:0] p;
        logic [4:0] idx;
        int         lb, r;
        longint     s, n, lmax;
        r = $urandom_range(0, 99);
        if (sb.st == ST_DONE) begin
            send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            return;
        end
        if (sb.st == ST_COPY) begin
            if (r < 3) send(kxpld_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            else send(kxpld_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            return;
        end
        if (r < 3) begin
            send(kxpld_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            return;
        end
        r = $urandom_range(0, 99);
        case (sb.st)
            ST_CMD: begin
                if (r < 45) begin
                    p = (r < 2) ? 8'h7E : 8'($urandom_range(0, 7));
                end else if (r < 50) begin
                    p = 8'h7F;
                end else begin
                    idx = 5'($urandom_range(0, 31));
                    lb = $urandom_range(0, 3);
                    n = (lb == 3) ? 4 : lb + 1;
                    s = sb.pos + sb.look(idx, sb.width_used());
                    if (s < 0 || s + n >= sb.total()) begin
                        idx = 0; lb = 0;
                    end
                    p = {1'b1, idx, lb[1:0]};
                end
            end
            ST_LIT_LO: p = 8'($urandom_range(0, 31));
            ST_COPY_LO: begin
                s = sb.pos + sb.look(sb.cmd[6:2], sb.width_used());
                lmax = sb.total() - s - 5;
                p = 8'($urandom_range(0, 15));
                if (p > lmax) p = 0;
            end
            ST_LIT_HI, ST_COPY_HI: p = 8'h00;
            default: p = 8'($urandom_range(0, 255));
        endcase
        send(kxpld_pkg::OP_BYTE, p);
    endtask

    task automatic run_phase(int count, bit with_hold);
        for (int i = 0; i < count || (sb.st != ST_CMD && sb.st != ST_DONE); i++) begin
            if (with_hold && i == count / 3) hold_req = 1;
            send_random();
        end
    endtask

    initial begin
        int v;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_regs(1024, 1, 0, 0);
        send(kxpld_pkg::OP_TICK, 8'h00);
        send(kxpld_pkg::OP_BYTE, 8'h00);
        send(kxpld_pkg::OP_BYTE, 8'hFF);
        send(kxpld_pkg::OP_BYTE, 8'h80);
        send(kxpld_pkg::OP_BYTE, 8'h02);
        for (int i = 0; i < 9; i++) send(kxpld_pkg::OP_BYTE, (i % 2) ? 8'hFF : 8'h5A);
        send(kxpld_pkg::OP_BYTE, 8'h80);
        send(kxpld_pkg::OP_BYTE, 8'h33);
        send(kxpld_pkg::OP_TICK, 8'h00);
        send(kxpld_pkg::OP_BYTE, 8'h81);
        send(kxpld_pkg::OP_TICK, 8'h00);
        send(kxpld_pkg::OP_TICK, 8'h00);
        send(kxpld_pkg::OP_BYTE, 8'h83);
        send(kxpld_pkg::OP_BYTE, 8'h00);
        send(kxpld_pkg::OP_BYTE, 8'h00);
        repeat (4) send(kxpld_pkg::OP_TICK, 8'h00);
        drain();

        write_regs(1, 1024, 1, 32'hFFFFFFFF);
        run_phase(300, 0);
        drain();
        write_regs($urandom_range(2, 1023), 1024, 1, $urandom);
        run_phase(400, 1);
        drain();
        // out-of-range width register clamps to the maximum
        write_regs(2047, 1024, 0, $urandom);
        run_phase(400, 0);
        drain();
        write_regs($urandom_range(8, 64), 1024, 1, $urandom);
        run_phase(400, 0);
        drain();

        v = $urandom_range(0, 2);
        if (v == 0) begin
            // far look-behind lands before the image start
            write_regs(1024, 1024, 32'(sb.enc), sb.key);
            send(kxpld_pkg::OP_BYTE, 8'hFC);
        end else if (v == 1) begin
            // image fills part-way through a literal run
            write_regs(32'((sb.pos + 3) / 2), 2, 32'(sb.enc), sb.key);
            send(kxpld_pkg::OP_BYTE, 8'h10);
            repeat (12) send(kxpld_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        end else begin
            // geometry shrinks below the write point
            write_regs(1, 1, 32'(sb.enc), sb.key);
        end
        repeat (10) send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        push <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
